>>> rtl/c2p_pkg.sv
// ----------------------------------------------------------------------------
// c2p_pkg
// Types and constants shared by the cartesian to polar converter: beat
// payloads, the queue entry, word widths and the arctangent table.
// ----------------------------------------------------------------------------
package c2p_pkg;

    localparam int C2P_COMP_W   = 16;
    localparam int C2P_ANGLE_W  = 16;
    localparam int C2P_TURN_W   = 32;
    localparam int C2P_CORDIC_W = 64;
    localparam int C2P_STEPS    = 32;
    localparam int C2P_GUARD    = 58 - C2P_COMP_W;
    localparam int C2P_SUM_W    = 2 * C2P_COMP_W;

    localparam logic [C2P_TURN_W-1:0] C2P_HALF_TURN = 32'h8000_0000;

    // atan(2^-i) as a fraction of a full turn, 32-bit
    localparam logic [C2P_TURN_W-1:0] C2P_ATAN_TURNS [0:C2P_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [C2P_COMP_W-1:0] x_component;
        logic signed [C2P_COMP_W-1:0] y_component;
    } t_c2p_in;

    typedef struct packed {
        logic [C2P_COMP_W-1:0]  magnitude;
        logic [C2P_ANGLE_W-1:0] angle_turns;
    } t_c2p_out;

    typedef struct packed {
        logic                       half_turn;
        logic                       zero;
        logic signed [C2P_COMP_W:0] x_fold;
        logic signed [C2P_COMP_W:0] y_fold;
        logic [C2P_SUM_W-1:0]       sum_sq;
    } t_c2p_work;

endpackage

>>> rtl/c2p_fifo.sv
// ----------------------------------------------------------------------------
// c2p_fifo
// Small register queue between the front and back halves of the converter.
// ----------------------------------------------------------------------------
module c2p_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/c2p_front.sv
// ----------------------------------------------------------------------------
// c2p_front
// Accepts input beats, folds the left half plane into the right, flags the
// zero vector and forms x*x + y*y for the root, then queues the work.
// ----------------------------------------------------------------------------
module c2p_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  c2p_pkg::t_c2p_in   i_data,
    output logic               o_push,
    output c2p_pkg::t_c2p_work o_work,
    input  logic               i_full
);

    localparam int CW = c2p_pkg::C2P_COMP_W;
    localparam int SW = c2p_pkg::C2P_SUM_W;

    logic                r_s1_valid;
    logic                r_s1_half;
    logic                r_s1_zero;
    logic signed [CW:0]  r_s1_xf;
    logic signed [CW:0]  r_s1_yf;
    logic [CW-1:0]       r_s1_ax;
    logic [CW-1:0]       r_s1_ay;

    logic                r_s2_valid;
    logic                r_s2_half;
    logic                r_s2_zero;
    logic signed [CW:0]  r_s2_xf;
    logic signed [CW:0]  r_s2_yf;
    logic [SW-1:0]       r_s2_px;
    logic [SW-1:0]       r_s2_py;

    logic                s1_ready;
    logic                s2_ready;
    logic signed [CW:0]  xe;
    logic signed [CW:0]  ye;
    logic signed [CW:0]  n_xf;
    logic signed [CW:0]  n_yf;
    logic signed [CW:0]  y_abs;

    assign o_push   = r_s2_valid && !i_full;
    assign s2_ready = !r_s2_valid || o_push;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_ready  = s1_ready;

    always_comb begin
        xe    = (CW+1)'(i_data.x_component);
        ye    = (CW+1)'(i_data.y_component);
        n_xf  = xe[CW] ? -xe : xe;
        n_yf  = xe[CW] ? -ye : ye;
        y_abs = ye[CW] ? -ye : ye;
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_half <= xe[CW];
            r_s1_zero <= (xe == '0) && (ye == '0);
            r_s1_xf   <= n_xf;
            r_s1_yf   <= n_yf;
            r_s1_ax   <= n_xf[CW-1:0];
            r_s1_ay   <= y_abs[CW-1:0];
        end
        if (s2_ready) begin
            r_s2_half <= r_s1_half;
            r_s2_zero <= r_s1_zero;
            r_s2_xf   <= r_s1_xf;
            r_s2_yf   <= r_s1_yf;
            r_s2_px   <= SW'(r_s1_ax) * SW'(r_s1_ax);
            r_s2_py   <= SW'(r_s1_ay) * SW'(r_s1_ay);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_comb begin
        o_work.half_turn = r_s2_half;
        o_work.zero      = r_s2_zero;
        o_work.x_fold    = r_s2_xf;
        o_work.y_fold    = r_s2_yf;
        o_work.sum_sq    = r_s2_px + r_s2_py;
    end

endmodule

>>> rtl/c2p_back.sv
// ----------------------------------------------------------------------------
// c2p_back
// Unrolled vectoring cordic for the angle, run alongside a digit-by-digit
// square root for the magnitude, one step per stage, then rounding.
// ----------------------------------------------------------------------------
module c2p_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_pop,
    input  c2p_pkg::t_c2p_work i_work,
    output logic               o_valid,
    input  logic               i_ready,
    output c2p_pkg::t_c2p_out  o_data
);

    localparam int CW    = c2p_pkg::C2P_COMP_W;
    localparam int AW    = c2p_pkg::C2P_ANGLE_W;
    localparam int TW    = c2p_pkg::C2P_TURN_W;
    localparam int DW    = c2p_pkg::C2P_CORDIC_W;
    localparam int SW    = c2p_pkg::C2P_SUM_W;
    localparam int G     = c2p_pkg::C2P_GUARD;
    localparam int STEPS = c2p_pkg::C2P_STEPS;
    localparam int EXT   = DW - (CW + 1) - G;

    logic signed [DW-1:0] r_x    [0:STEPS];
    logic signed [DW-1:0] r_y    [0:STEPS];
    logic [TW-1:0]        r_z    [0:STEPS];
    logic [SW-1:0]        r_n    [0:STEPS];
    logic [CW-1:0]        r_root [0:STEPS];
    logic [CW+1:0]        r_rem  [0:STEPS];
    logic                 r_zero [0:STEPS];
    logic [STEPS:0]       r_valid;

    logic                 r_out_valid;
    c2p_pkg::t_c2p_out    r_out;

    logic                 en;
    logic [CW-1:0]        mag;
    logic [AW-1:0]        ang;

    assign en      = !r_out_valid || i_ready;
    assign o_pop   = en && i_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0]    <= {{EXT{i_work.x_fold[CW]}}, i_work.x_fold, {G{1'b0}}};
            r_y[0]    <= {{EXT{i_work.y_fold[CW]}}, i_work.y_fold, {G{1'b0}}};
            r_z[0]    <= i_work.half_turn ? c2p_pkg::C2P_HALF_TURN : '0;
            r_n[0]    <= i_work.sum_sq;
            r_root[0] <= '0;
            r_rem[0]  <= '0;
            r_zero[0] <= i_work.zero;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic signed [DW-1:0] xs;
        logic signed [DW-1:0] ys;
        logic signed [DW-1:0] n_x;
        logic signed [DW-1:0] n_y;
        logic [TW-1:0]        n_z;
        logic [SW-1:0]        n_n;
        logic [CW-1:0]        n_root;
        logic [CW+1:0]        n_rem;

        always_comb begin
            xs = r_x[k] >>> k;
            ys = r_y[k] >>> k;
            if (!r_y[k][DW-1]) begin
                n_x = r_x[k] + ys;
                n_y = r_y[k] - xs;
                n_z = r_z[k] + c2p_pkg::C2P_ATAN_TURNS[k];
            end else begin
                n_x = r_x[k] - ys;
                n_y = r_y[k] + xs;
                n_z = r_z[k] - c2p_pkg::C2P_ATAN_TURNS[k];
            end
        end

        if (k < CW) begin : g_sqrt
            logic [CW+1:0] rem2;
            logic [CW+1:0] trial;
            logic          ge;
            always_comb begin
                rem2   = {r_rem[k][CW-1:0], r_n[k][SW-1 -: 2]};
                trial  = {r_root[k], 2'b01};
                ge     = (rem2 >= trial);
                n_rem  = ge ? rem2 - trial : rem2;
                n_root = {r_root[k][CW-2:0], ge};
                n_n    = r_n[k] << 2;
            end
        end else begin : g_pass
            always_comb begin
                n_rem  = r_rem[k];
                n_root = r_root[k];
                n_n    = r_n[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_x[k+1]    <= n_x;
                r_y[k+1]    <= n_y;
                r_z[k+1]    <= n_z;
                r_n[k+1]    <= n_n;
                r_root[k+1] <= n_root;
                r_rem[k+1]  <= n_rem;
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    // round half up on the root remainder
    assign mag = r_root[STEPS] + CW'(r_rem[STEPS] > {2'b00, r_root[STEPS]});

    if (AW < TW) begin : g_round
        logic [TW-1:0] rnd;
        assign rnd = r_z[STEPS] + (TW'(1) << (TW - 1 - AW));
        assign ang = rnd[TW-1 -: AW];
    end else begin : g_full
        assign ang = r_z[STEPS][TW-1 -: AW];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.magnitude   <= mag;
            r_out.angle_turns <= r_zero[STEPS] ? '0 : ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_valid     <= {r_valid[STEPS-1:0], o_pop};
            r_out_valid <= r_valid[STEPS];
        end
    end

endmodule

>>> rtl/cartesian_to_polar_top.sv
// ----------------------------------------------------------------------------
// cartesian_to_polar_top
// Signed (x, y) in, rounded magnitude and angle as a fraction of a turn out.
// beat path: front s1 and s2, queue, cordic entry and steps, output register
// throughput: one beat per cycle unless stalled; 32-stage unrolled cordic pipe
// a stalled output holds the whole back pipe; the queue absorbs the front
// reset: synchronous active-low, clears all valid flags and queue pointers
// ----------------------------------------------------------------------------
module cartesian_to_polar_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  c2p_pkg::t_c2p_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output c2p_pkg::t_c2p_out o_out_data
);

    c2p_pkg::t_c2p_work w_push_work;
    c2p_pkg::t_c2p_work w_pop_work;
    logic               w_push;
    logic               w_full;
    logic               w_pop;
    logic               w_q_valid;

    c2p_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_push  (w_push),
        .o_work  (w_push_work),
        .i_full  (w_full)
    );

    c2p_fifo #(
        .WIDTH ($bits(c2p_pkg::t_c2p_work)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_work),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_pop_work)
    );

    c2p_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_pop   (w_pop),
        .i_work  (w_pop_work),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

>>> rtl/c2p_checker.sv
// ----------------------------------------------------------------------------
// c2p_checker
// Port-level checks on the converter: beat bookkeeping, reset and stalls.
// ----------------------------------------------------------------------------
module c2p_checker #(
    parameter int QUEUE_DEPTH = 4
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input c2p_pkg::t_c2p_out o_out_data
);

    // front stages, queue, cordic stages plus entry, output register
    localparam int CAP   = QUEUE_DEPTH + 2 + c2p_pkg::C2P_STEPS + 2;
    localparam int CNT_W = $clog2(CAP + 1) + 1;

    logic [CNT_W-1:0] r_pending;
    logic             in_beat;
    logic             out_beat;

    assign in_beat  = i_in_valid && o_in_ready;
    assign out_beat = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_beat && !out_beat) begin
            r_pending <= r_pending + 1'b1;
        end else if (out_beat && !in_beat) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_no_invented_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pending != '0))
        else $error("output beat with no input beat outstanding");

    a_bounded_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= CNT_W'(CAP))
        else $error("more beats in flight than the pipe can hold");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

endmodule

bind cartesian_to_polar_top c2p_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_c2p_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

>>> tb/sv/cartesian_to_polar_top_tb.sv
// ----------------------------------------------------------------------------
// cartesian_to_polar_top_tb
// Self-checking bench for the cartesian to polar converter. A directed table
// covers the zero vector, the axis and diagonal extremes, both sides of the
// half turn and the wrap just below a full turn; random vectors follow.
// Known rows are checked against the table, others against an in-bench square
// root and cordic predictor, with random idling on both the input and output.
// ----------------------------------------------------------------------------
module cartesian_to_polar_top_tb;

    localparam int RANDOM_VECTORS = 2000;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int IDLE_PCT       = 34;
    localparam int QUIET_FIRST    = 700;
    localparam int QUIET_LAST     = 1100;
    localparam int ROT_GUARD      = 58 - c2p_pkg::C2P_COMP_W;
    localparam logic [c2p_pkg::C2P_TURN_W-1:0] TURN_HALF = 32'h8000_0000;

    localparam logic [31:0] ARCTAN_TURNS [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [c2p_pkg::C2P_COMP_W-1:0] x;
        logic signed [c2p_pkg::C2P_COMP_W-1:0] y;
        logic                                  known;
        logic [c2p_pkg::C2P_COMP_W-1:0]        mag;
        logic [c2p_pkg::C2P_ANGLE_W-1:0]       ang;
    } t_vector_row;

    localparam int DIRECTED_ROWS = 24;
    localparam t_vector_row DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{16'sd0,      16'sd0,      1'b1, 16'd0,     16'd0},
        '{16'sd32767,  16'sd0,      1'b1, 16'd32767, 16'd0},
        '{16'sd0,      16'sd32767,  1'b1, 16'd32767, 16'd16384},
        '{-16'sd32768, 16'sd0,      1'b1, 16'd32768, 16'd32768},
        '{16'sd0,      -16'sd32768, 1'b1, 16'd32768, 16'd49152},
        '{16'sd32767,  16'sd32767,  1'b1, 16'd46340, 16'd8192},
        '{-16'sd32768, -16'sd32768, 1'b1, 16'd46341, 16'd40960},
        '{16'sd32767,  -16'sd1,     1'b1, 16'd32767, 16'd0},
        '{16'sd32767,  -16'sd2,     1'b0, 16'd0,     16'd0},
        '{16'sd1,      16'sd0,      1'b0, 16'd0,     16'd0},
        '{16'sd0,      16'sd1,      1'b0, 16'd0,     16'd0},
        '{-16'sd1,     16'sd0,      1'b0, 16'd0,     16'd0},
        '{16'sd0,      -16'sd1,     1'b0, 16'd0,     16'd0},
        '{-16'sd1,     -16'sd1,     1'b0, 16'd0,     16'd0},
        '{16'sd1,      -16'sd1,     1'b0, 16'd0,     16'd0},
        '{-16'sd32768, 16'sd32767,  1'b0, 16'd0,     16'd0},
        '{16'sd32767,  -16'sd32768, 1'b0, 16'd0,     16'd0},
        '{-16'sd32768, 16'sd1,      1'b0, 16'd0,     16'd0},
        '{-16'sd32768, -16'sd1,     1'b0, 16'd0,     16'd0},
        '{-16'sd1,     16'sd32767,  1'b0, 16'd0,     16'd0},
        '{16'sd1,      -16'sd32768, 1'b0, 16'd0,     16'd0},
        '{16'sd21845,  -16'sd21846, 1'b0, 16'd0,     16'd0},
        '{-16'sd21846, 16'sd21845,  1'b0, 16'd0,     16'd0},
        '{16'sd12345,  -16'sd6789,  1'b0, 16'd0,     16'd0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    c2p_pkg::t_c2p_in   i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    c2p_pkg::t_c2p_out  o_out_data;

    t_vector_row        vectors [$];
    c2p_pkg::t_c2p_out  pending_polar [$];
    int                 taken_count;
    int                 cycle_count;
    int                 fail_count;
    logic               drive_on;
    logic               in_beat;

    cartesian_to_polar_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [c2p_pkg::C2P_COMP_W-1:0] rounded_length(
        input logic [63:0] sum_sq
    );
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem   = sum_sq;
        root  = '0;
        probe = 64'h1 << 62;
        while (probe > sum_sq) probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        if (rem > root) root = root + 64'd1;
        return root[c2p_pkg::C2P_COMP_W-1:0];
    endfunction

    function automatic logic [c2p_pkg::C2P_ANGLE_W-1:0] vector_turns(
        input logic signed [c2p_pkg::C2P_COMP_W-1:0] xc,
        input logic signed [c2p_pkg::C2P_COMP_W-1:0] yc
    );
        logic signed [63:0]             xr;
        logic signed [63:0]             yr;
        logic signed [63:0]             xs;
        logic signed [63:0]             ys;
        logic [c2p_pkg::C2P_TURN_W-1:0] acc;
        logic [c2p_pkg::C2P_TURN_W:0]   rounded;
        int                             step;
        xr  = xc;
        yr  = yc;
        acc = '0;
        if (xr < 0) begin
            xr  = -xr;
            yr  = -yr;
            acc = TURN_HALF;
        end
        xr = xr <<< ROT_GUARD;
        yr = yr <<< ROT_GUARD;
        for (step = 0; step < c2p_pkg::C2P_STEPS; step++) begin
            xs = xr >>> step;
            ys = yr >>> step;
            if (yr >= 0) begin
                xr  = xr + ys;
                yr  = yr - xs;
                acc = acc + ARCTAN_TURNS[step];
            end else begin
                xr  = xr - ys;
                yr  = yr + xs;
                acc = acc - ARCTAN_TURNS[step];
            end
        end
        rounded = {1'b0, acc}
                + (33'd1 << (c2p_pkg::C2P_TURN_W - c2p_pkg::C2P_ANGLE_W - 1));
        return rounded[c2p_pkg::C2P_TURN_W-1 -: c2p_pkg::C2P_ANGLE_W];
    endfunction

    function automatic c2p_pkg::t_c2p_out polar_of(input c2p_pkg::t_c2p_in vec);
        c2p_pkg::t_c2p_out res;
        logic [63:0]       ax;
        logic [63:0]       ay;
        ax = (vec.x_component < 0) ? 64'(-64'(vec.x_component)) : 64'(vec.x_component);
        ay = (vec.y_component < 0) ? 64'(-64'(vec.y_component)) : 64'(vec.y_component);
        res.magnitude = rounded_length(ax * ax + ay * ay);
        if (vec.x_component == 0 && vec.y_component == 0) res.angle_turns = '0;
        else res.angle_turns = vector_turns(vec.x_component, vec.y_component);
        return res;
    endfunction

    function automatic logic [c2p_pkg::C2P_COMP_W-1:0] edge_value();
        case ($urandom_range(0, 6))
            0: return 16'h8000;
            1: return 16'h8001;
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'h0001;
            5: return 16'h7FFE;
            default: return 16'h7FFF;
        endcase
    endfunction

    function automatic t_vector_row random_row();
        t_vector_row row;
        row = '0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                row.x = 16'($urandom);
                row.y = 16'($urandom);
            end
            4: begin
                row.x = 16'($urandom_range(0, 32) - 16);
                row.y = 16'($urandom_range(0, 32) - 16);
            end
            5: begin
                row.x = 16'($urandom);
                row.y = 16'($urandom_range(0, 6) - 3);
            end
            6: begin
                row.x = 16'($urandom_range(0, 6) - 3);
                row.y = 16'($urandom);
            end
            7: begin
                row.x = edge_value();
                row.y = edge_value();
            end
            default: begin
                row.x = 16'($urandom);
                row.y = $urandom_range(0, 1) ? row.x : -row.x;
            end
        endcase
        return row;
    endfunction

    function automatic logic idle_draw();
        if (taken_count >= QUIET_FIRST && taken_count < QUIET_LAST) return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // input side: hold an unaccepted beat, otherwise offer the next or idle
    always @(negedge i_clk) begin
        if (drive_on) begin
            if (i_in_valid && !in_beat) begin
            end else if (taken_count < vectors.size() && !idle_draw()) begin
                i_in_valid <= 1'b1;
                i_in_data  <= '{x_component: vectors[taken_count].x,
                               y_component: vectors[taken_count].y};
            end else begin
                i_in_valid <= 1'b0;
            end
            i_out_ready <= !idle_draw();
        end
    end

    always @(posedge i_clk) begin
        c2p_pkg::t_c2p_out got;
        c2p_pkg::t_c2p_out want;
        in_beat = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                in_beat = 1'b1;
                if (vectors[taken_count].known)
                    pending_polar.push_back('{magnitude: vectors[taken_count].mag,
                                              angle_turns: vectors[taken_count].ang});
                else
                    pending_polar.push_back(polar_of(i_in_data));
                taken_count++;
            end
            if (o_out_valid && i_out_ready) begin
                got = o_out_data;
                if (pending_polar.size() == 0) begin
                    $error("unexpected output beat: magnitude %0d angle_turns %0d",
                           got.magnitude, got.angle_turns);
                    fail_count++;
                end else begin
                    want = pending_polar.pop_front();
                    if (got.magnitude !== want.magnitude) begin
                        $error("magnitude: expected %0d, actual %0d",
                               want.magnitude, got.magnitude);
                        fail_count++;
                    end
                    if (got.angle_turns !== want.angle_turns) begin
                        $error("angle_turns: expected %0d, actual %0d",
                               want.angle_turns, got.angle_turns);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        drive_on    = 1'b0;
        in_beat     = 1'b0;
        taken_count = 0;
        cycle_count = 0;
        fail_count  = 0;

        for (int r = 0; r < DIRECTED_ROWS; r++) vectors.push_back(DIRECTED[r]);
        repeat (RANDOM_VECTORS) vectors.push_back(random_row());

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  = 1'b1;
        drive_on = 1'b1;

        while (taken_count < vectors.size()) @(posedge i_clk);
        while (pending_polar.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
